@@ hw/rtl/grr_pkg.sv @@
package grr_pkg;

   localparam int VALUE_W  = 32;
   localparam int GS_W     = 5;
   localparam logic [GS_W-1:0] GS_RESET = GS_W'(1);

   typedef enum logic {
      ST_FILL,
      ST_DRAIN
   } grr_state_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;       // take the request word into the group store
      logic start_drain;  // latch run length, order and end flag
      logic load;         // move the next stored word into the response register
   } grr_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic drain_go;     // the offered word completes a group or ends the list
      logic out_free;     // response register can take a word this cycle
      logic rem_one;      // one word left in the current run
   } grr_status_type;

endpackage

@@ hw/rtl/grr_req_if.sv @@
interface grr_req_if
   import grr_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] in_value;
   logic                      in_list_end;

   modport source (output valid, output in_value, output in_list_end, input ready);
   modport sink   (input valid, input in_value, input in_list_end, output ready);
endinterface

@@ hw/rtl/grr_rsp_if.sv @@
interface grr_rsp_if
   import grr_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] out_value;
   logic                      run_last;
   logic                      out_list_end;

   modport source (output valid, output out_value, output run_last, output out_list_end,
                   input ready);
   modport sink   (input valid, input out_value, input run_last, input out_list_end,
                   output ready);
endinterface

@@ hw/rtl/grr_ctrl.sv @@
module grr_ctrl
   import grr_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  grr_status_type status,
   output logic           req_ready,
   output grr_cmd_type    cmd
);

   grr_state_type state_ff;
   grr_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FILL;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_FILL: begin
            if (req_valid && status.drain_go) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (status.out_free && status.rem_one) begin
               state_in = ST_FILL;
            end
         end
         default: state_in = ST_FILL;
      endcase
   end

   always_comb begin
      req_ready        = 1'b0;
      cmd.accept       = 1'b0;
      cmd.start_drain  = 1'b0;
      cmd.load         = 1'b0;
      unique case (state_ff)
         ST_FILL: begin
            req_ready       = 1'b1;
            cmd.accept      = req_valid;
            cmd.start_drain = req_valid && status.drain_go;
         end
         ST_DRAIN: begin
            cmd.load = status.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

@@ hw/rtl/grr_datapath.sv @@
module grr_datapath
   import grr_pkg::*;
#(
   parameter int K_MAX = 16
)(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [GS_W-1:0]           csr_wdata,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic                      req_list_end,
   input  logic                      rsp_ready,
   input  grr_cmd_type               cmd,
   output grr_status_type            status,
   output logic                      rsp_valid,
   output logic signed [VALUE_W-1:0] rsp_value,
   output logic                      rsp_run_last,
   output logic                      rsp_list_end
);

   localparam int CW = $clog2(K_MAX + 1);
   localparam int AW = (K_MAX > 1) ? $clog2(K_MAX) : 1;
   localparam int KW = (CW > GS_W) ? CW : GS_W;

   logic signed [VALUE_W-1:0] mem [K_MAX];

   logic [GS_W-1:0] gs_ff;
   logic [CW-1:0]   fill_ff, fill_in;
   logic [CW-1:0]   rem_ff, rem_in;
   logic [AW-1:0]   addr_ff, addr_in;
   logic            rev_ff, rev_in;
   logic            end_ff, end_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_W-1:0] rsp_value_ff;
   logic            rsp_last_ff;
   logic            rsp_end_ff;

   logic [KW-1:0]   gs_ext;
   logic [KW-1:0]   k_eff;
   logic [CW-1:0]   n_new;
   logic            room;
   logic            grp_full;

   // clamp the group size into 1..K_MAX
   always_comb begin
      gs_ext = KW'(gs_ff);
      if (gs_ff == '0) begin
         k_eff = KW'(1);
      end else if (gs_ext > KW'(K_MAX)) begin
         k_eff = KW'(K_MAX);
      end else begin
         k_eff = gs_ext;
      end
      room     = (fill_ff < CW'(K_MAX));
      n_new    = room ? fill_ff + CW'(1) : fill_ff;
      grp_full = (KW'(n_new) >= k_eff);
   end

   assign status.drain_go = grp_full || req_list_end;
   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign status.rem_one  = (rem_ff == CW'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         gs_ff <= GS_RESET;
      end else if (csr_we) begin
         gs_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && room) begin
         mem[fill_ff[AW-1:0]] <= req_value;
      end
   end

   always_comb begin
      fill_in = fill_ff;
      rem_in  = rem_ff;
      addr_in = addr_ff;
      rev_in  = rev_ff;
      end_in  = end_ff;
      if (cmd.start_drain) begin
         fill_in = '0;
         rem_in  = n_new;
         rev_in  = grp_full;
         end_in  = req_list_end;
         addr_in = grp_full ? AW'(n_new - CW'(1)) : '0;
      end else if (cmd.accept) begin
         fill_in = n_new;
      end else if (cmd.load) begin
         rem_in  = rem_ff - CW'(1);
         addr_in = rev_ff ? addr_ff - AW'(1) : addr_ff + AW'(1);
      end
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      rev_ff  <= rev_in;
      end_ff  <= end_in;
   end

   // the response register doubles as the store's read register
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_value_ff <= mem[addr_ff];
         rsp_last_ff  <= (rem_ff == CW'(1));
         rsp_end_ff   <= (rem_ff == CW'(1)) && end_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_value    = rsp_value_ff;
   assign rsp_run_last = rsp_last_ff;
   assign rsp_list_end = rsp_end_ff;

endmodule

@@ hw/rtl/group_reverse_reorder_core.sv @@
// Channel   Dir  Payload                                   Handshake
// req_if    in   in_value[31:0] signed, in_list_end        valid/ready
// rsp_if    out  out_value[31:0] signed, run_last,         valid/ready
//                out_list_end
// csr       in   csr_wdata[4:0] group size                 csr_we, no wait
//
// A word that neither completes a group nor ends the list is only stored.
// A word that closes a run of n words is stored and starts a drain of n words; the
// single read port of the group store gives one response word per cycle unless stalled.
// Requests are held off while a run drains; a stalled response holds the drain.
// Reset (synchronous) empties the group store and sets group size to 1.
module group_reverse_reorder_core
   import grr_pkg::*;
#(
   parameter int K_MAX = 16
)(
   input  logic            clock,
   input  logic            reset,
   grr_req_if.sink         req_if,
   grr_rsp_if.source       rsp_if,
   input  logic            csr_we,
   input  logic [GS_W-1:0] csr_wdata
);

   grr_cmd_type    cmd;
   grr_status_type status;

   grr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .status    (status),
      .req_ready (req_if.ready),
      .cmd       (cmd)
   );

   grr_datapath #(
      .K_MAX (K_MAX)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .req_value    (req_if.in_value),
      .req_list_end (req_if.in_list_end),
      .rsp_ready    (rsp_if.ready),
      .cmd          (cmd),
      .status       (status),
      .rsp_valid    (rsp_if.valid),
      .rsp_value    (rsp_if.out_value),
      .rsp_run_last (rsp_if.run_last),
      .rsp_list_end (rsp_if.out_list_end)
   );

endmodule

@@ verif/group_reverse_reorder_checker.sv @@
`timescale 1ns / 1ps

module group_reverse_reorder_checker
   import grr_pkg::*;
#(
   parameter int K_MAX = 16
)(
   input  logic            clock,
   input  logic            reset,
   grr_req_if              req_mon,
   grr_rsp_if              rsp_mon,
   input  logic            csr_we,
   input  logic [GS_W-1:0] csr_wdata,
   output int              pending_words,
   output int              mismatch_count
);

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      run_last;
      logic                      list_end;
   } rsp_word_type;

   rsp_word_type              reorder_q[$];
   logic signed [VALUE_W-1:0] held_words [K_MAX];
   int                        held_count = 0;
   logic [GS_W-1:0]           group_size = GS_RESET;
   int                        errors = 0;

   function automatic int active_size(input logic [GS_W-1:0] size);
      if (size == 0) begin
         return 1;
      end
      if (int'(size) > K_MAX) begin
         return K_MAX;
      end
      return int'(size);
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t: mismatch: %s", $time, what);
      errors++;
   endtask

   // A full group leaves reversed; a short tail at list end leaves in order.
   task automatic absorb_word(input logic signed [VALUE_W-1:0] value, input logic list_end);
      int n;
      int k;
      int i;
      k = active_size(group_size);
      if (held_count < K_MAX) begin
         held_words[held_count] = value;
         held_count++;
      end
      n = held_count;
      if (n >= k) begin
         for (i = 0; i < n; i++) begin
            reorder_q.push_back(rsp_word_type'{held_words[n-1-i], i == n-1,
                                               (i == n-1) && list_end});
         end
         held_count = 0;
      end else if (list_end) begin
         for (i = 0; i < n; i++) begin
            reorder_q.push_back(rsp_word_type'{held_words[i], i == n-1, i == n-1});
         end
         held_count = 0;
      end
   endtask

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         held_count = 0;
         group_size = GS_RESET;
         reorder_q.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (reorder_q.size() == 0) begin
               report_mismatch($sformatf("unexpected word %h", rsp_mon.out_value));
            end else begin
               want = reorder_q.pop_front();
               if (rsp_mon.out_value !== want.value) begin
                  report_mismatch($sformatf("out_value got %h want %h",
                                            rsp_mon.out_value, want.value));
               end
               if (rsp_mon.run_last !== want.run_last) begin
                  report_mismatch($sformatf("run_last got %b want %b (value %h)",
                                            rsp_mon.run_last, want.run_last, want.value));
               end
               if (rsp_mon.out_list_end !== want.list_end) begin
                  report_mismatch($sformatf("out_list_end got %b want %b (value %h)",
                                            rsp_mon.out_list_end, want.list_end, want.value));
               end
            end
         end
         // A word taken on the write edge still sees the old group size.
         if (req_mon.valid && req_mon.ready) begin
            absorb_word(req_mon.in_value, req_mon.in_list_end);
         end
         if (csr_we) begin
            group_size = csr_wdata;
         end
      end
      pending_words  <= reorder_q.size();
      mismatch_count <= errors;
   end

endmodule

@@ verif/group_reverse_reorder_core_tb.sv @@
`timescale 1ns / 1ps

module group_reverse_reorder_core_tb
   import grr_pkg::*;
();

   localparam int K_MAX        = 16;
   localparam int RANDOM_WORDS = 360;
   localparam int QUIET_WORDS  = 60;

   logic            clock;
   logic            reset;
   logic            csr_we;
   logic [GS_W-1:0] csr_wdata;
   int              pending_words;
   int              mismatch_count;
   bit              stall_enable;
   bit              gap_enable;
   int              stall_left;

   grr_req_if req_ch();
   grr_rsp_if rsp_ch();

   group_reverse_reorder_core #(.K_MAX(K_MAX)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch.sink),
      .rsp_if    (rsp_ch.source),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   group_reverse_reorder_checker #(.K_MAX(K_MAX)) checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_ch),
      .rsp_mon        (rsp_ch),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .pending_words  (pending_words),
      .mismatch_count (mismatch_count)
   );

   initial begin
      clock = 1'b0;
   end

   always #5 clock = ~clock;

   // Random response back-pressure in bursts while stall_enable is set.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b1;
         stall_left   <= 0;
      end else if (stall_left > 0) begin
         stall_left   <= stall_left - 1;
         rsp_ch.ready <= (stall_left == 1);
      end else if (stall_enable && $urandom_range(0, 7) == 0) begin
         stall_left   <= $urandom_range(1, 18);
         rsp_ch.ready <= 1'b0;
      end
   end

   initial begin
      #5_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'hFFFF_FFFF;
         3:       return 32'h0000_0000;
         4:       return VALUE_W'($urandom_range(0, 255));
         default: return $urandom();
      endcase
   endfunction

   // Leave valid high on return; the next word or a gap decides what follows.
   task automatic send_word(input logic [VALUE_W-1:0] value, input logic list_end);
      int gap;
      if (gap_enable && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 18);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.in_value    <= value;
      req_ch.in_list_end <= list_end;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // Hold off until every expected word has arrived, then let the core settle.
   task automatic drain_responses();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_group_size(input logic [GS_W-1:0] size);
      csr_we    <= 1'b1;
      csr_wdata <= size;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin
      int sent;
      int phase;
      int phase_words;
      int list_left;
      int size;
      int i;
      bit quiet;
      logic list_end;

      reset              <= 1'b1;
      csr_we             <= 1'b0;
      csr_wdata          <= GS_RESET;
      req_ch.valid       <= 1'b0;
      req_ch.in_value    <= '0;
      req_ch.in_list_end <= 1'b0;
      stall_enable       <= 1'b0;
      gap_enable = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Group size 1 from reset: straight pass, list end on a full group.
      send_word(32'h7FFF_FFFF, 1'b0);
      send_word(32'h8000_0000, 1'b1);
      drain_responses();

      // Largest group, closed by the list end.
      write_group_size(GS_W'(K_MAX));
      for (i = 0; i < K_MAX; i++) begin
         case (i)
            0:       send_word(32'h0000_0000, 1'b0);
            1:       send_word(32'hFFFF_FFFF, 1'b0);
            default: send_word((i[0] ? 32'hAAAA_AAAA : 32'h5555_5555) ^ i, i == K_MAX-1);
         endcase
      end
      // List shorter than the group passes through in order.
      send_word(32'h0000_0001, 1'b0);
      send_word(32'hFFFF_FFFE, 1'b1);
      // Shrink the group below the held count.
      for (i = 0; i < 4; i++) begin
         send_word(32'h1000_0000 + i, 1'b0);
      end
      drain_responses();
      write_group_size(GS_W'(2));
      send_word(32'h2000_0000, 1'b1);

      sent  = 0;
      phase = 0;
      while (sent < RANDOM_WORDS) begin
         drain_responses();
         quiet = (sent >= RANDOM_WORDS - QUIET_WORDS);
         gap_enable = !quiet && ($urandom_range(0, 3) != 0);
         stall_enable <= !quiet && ($urandom_range(0, 3) != 0);
         case (phase)
            0:       size = K_MAX;
            1:       size = 1;
            default: size = $urandom_range(1, K_MAX);
         endcase
         write_group_size(GS_W'(size));
         phase_words = $urandom_range(20, 50);
         list_left   = 0;
         // Phases end mid-list at random, so the next size meets a held group.
         while (phase_words > 0 && sent < RANDOM_WORDS) begin
            if (list_left == 0) begin
               list_left = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 40)
                                                       : $urandom_range(1, 2*size + 2);
            end
            list_end = (list_left == 1) || ($urandom_range(0, 19) == 0);
            send_word(pick_value(), list_end);
            list_left = list_end ? 0 : list_left - 1;
            phase_words--;
            sent++;
         end
         phase++;
      end

      drain_responses();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
